/* hdl/ufe_pkg.sv */
// ----------------------------------------------------------------------------
// ufe_pkg: union-find engine shared definitions
// Index and size widths, item kind codes and the token that walks the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package ufe_pkg;

    localparam int IDX_W  = 6;
    localparam int SIZE_W = 7;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [1:0]        t_kind;

    localparam t_kind KIND_UNITE = 2'd0;
    localparam t_kind KIND_FIND  = 2'd1;
    localparam t_kind KIND_TEST  = 2'd2;

    // Token handed from cell to cell.
    // Lookup pass: a/b are the element indexes, ra/rb and sa/sb pick up
    // root and set size of each element as the token passes its cell.
    // Relabel pass: members of ra or rb move to root nr, size sa (the sum).
    typedef struct packed {
        logic  vld;
        logic  rel;
        t_idx  a;
        t_idx  b;
        t_idx  ra;
        t_idx  rb;
        t_idx  nr;
        t_size sa;
        t_size sb;
    } t_tok;

endpackage

`default_nettype wire

/* hdl/ufe_if.sv */
// ----------------------------------------------------------------------------
// ufe_if: union-find engine channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufe_in_if;
    logic          valid;
    logic          ready;
    ufe_pkg::t_kind kind;
    ufe_pkg::t_idx  first_index;
    ufe_pkg::t_idx  second_index;

    modport source (output valid, output kind, output first_index,
                    output second_index, input ready);
    modport sink   (input valid, input kind, input first_index,
                    input second_index, output ready);
endinterface

interface ufe_out_if;
    logic          valid;
    logic          ready;
    ufe_pkg::t_idx  root_first;
    ufe_pkg::t_idx  root_second;
    logic          same_set;
    ufe_pkg::t_size set_size;

    modport source (output valid, output root_first, output root_second,
                    output same_set, output set_size, input ready);
    modport sink   (input valid, input root_first, input root_second,
                    input same_set, input set_size, output ready);
endinterface

`default_nettype wire

/* hdl/ufe_cell.sv */
// ----------------------------------------------------------------------------
// ufe_cell: one cell of the union-find row
// Holds root label and set size for a group of elements; updates or reads
// them from the passing token and registers the token for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ufe_cell #(
    parameter int BASE  = 0,
    parameter int SLOTS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire ufe_pkg::t_tok   i_tok,
    output ufe_pkg::t_tok        o_tok
);

    localparam int IW = ufe_pkg::IDX_W;
    localparam int SW = ufe_pkg::SIZE_W;

    ufe_pkg::t_idx  w_slot [SLOTS];
    ufe_pkg::t_idx  r_root [SLOTS];
    ufe_pkg::t_idx  n_root [SLOTS];
    ufe_pkg::t_size r_size [SLOTS];
    ufe_pkg::t_size n_size [SLOTS];
    ufe_pkg::t_tok  r_tok;
    ufe_pkg::t_tok  n_tok;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_slot
            assign w_slot[g] = IW'(BASE + g);
        end
    endgenerate

    always_comb begin
        n_tok  = i_tok;
        n_root = r_root;
        n_size = r_size;
        for (int j = 0; j < SLOTS; j++) begin
            if (i_tok.vld && !i_tok.rel) begin
                if (i_tok.a == w_slot[j]) begin
                    n_tok.ra = r_root[j];
                    n_tok.sa = r_size[j];
                end
                if (i_tok.b == w_slot[j]) begin
                    n_tok.rb = r_root[j];
                    n_tok.sb = r_size[j];
                end
            end else if (i_tok.vld && i_tok.rel) begin
                // both old sets move to the merged root
                if (r_root[j] == i_tok.ra || r_root[j] == i_tok.rb) begin
                    n_root[j] = i_tok.nr;
                    n_size[j] = i_tok.sa;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) begin
                r_root[j] <= w_slot[j];
                r_size[j] <= SW'(1);
            end
            r_tok <= '0;
        end else begin
            r_root <= n_root;
            r_size <= n_size;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hdl/union_find_engine.sv */
// ----------------------------------------------------------------------------
// union_find_engine: disjoint-set table on a row of cells
// Unite, find and same-set test over up to ELEMENTS elements; each item
// returns both roots, a same-set flag and the first element's set size.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    kind, first_index, second_index
//  o_out    out  valid/ready    root_first, root_second, same_set, set_size
//
//  Row: CELLS cells (4 at the default); the token is registered in each cell
//  in turn. Find/test items make a single lookup pass through the row.
//  Unite of two distinct sets: a second relabel pass after the lookup pass.
//  Reset: synchronous, every element back to a set of its own, no pass.
//  Stalls: one item in flight; o_out holds a result while the next item runs,
//  a finished item waits in the controller until o_out frees.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_engine #(
    parameter int ELEMENTS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ufe_in_if.sink     i_in,
    ufe_out_if.source  o_out
);

    localparam int IW = ufe_pkg::IDX_W;
    localparam int SW = ufe_pkg::SIZE_W;

    // Indexes are 6 bits wide, so only the first 64 elements can ever be
    // reached; elements above that stay singletons and get no cell slot.
    localparam int NCELL = (ELEMENTS < (1 << IW)) ? ELEMENTS : (1 << IW);
    localparam int PER   = (NCELL + 3) / 4;
    localparam int CELLS = (NCELL + PER - 1) / PER;

    // controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_REL  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]     r_state, n_state;
    ufe_pkg::t_kind r_kind, n_kind;

    // finished result waiting for the output register
    ufe_pkg::t_idx  r_res_ra, n_res_ra;
    ufe_pkg::t_idx  r_res_rb, n_res_rb;
    logic           r_res_same, n_res_same;
    ufe_pkg::t_size r_res_size, n_res_size;

    // output register
    logic           r_ov, n_ov;
    ufe_pkg::t_idx  r_out_ra, n_out_ra;
    ufe_pkg::t_idx  r_out_rb, n_out_rb;
    logic           r_out_same, n_out_same;
    ufe_pkg::t_size r_out_size, n_out_size;

    ufe_pkg::t_tok  w_chain [CELLS+1];
    ufe_pkg::t_tok  w_launch;
    ufe_pkg::t_tok  w_ret;
    logic [CELLS-1:0] w_vlds;
    logic           w_accept;
    ufe_pkg::t_idx  w_nr;
    ufe_pkg::t_size w_sum;

    // index wrap table: i mod ELEMENTS, worked out at elaboration
    ufe_pkg::t_idx  w_wrap [1 << IW];

    genvar g;
    generate
        for (g = 0; g < (1 << IW); g++) begin : g_wrap
            assign w_wrap[g] = IW'(g % ELEMENTS);
        end
        for (g = 0; g < CELLS; g++) begin : g_cell
            ufe_cell #(
                .BASE  (g * PER),
                .SLOTS (PER)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_chain[g]),
                .o_tok   (w_chain[g+1])
            );
        end
        // tokens held in the cell registers
        for (g = 0; g < CELLS; g++) begin : g_vld
            assign w_vlds[g] = w_chain[g+1].vld;
        end
    endgenerate

    assign w_chain[0] = w_launch;
    assign w_ret      = w_chain[CELLS];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);

    // merge: smaller root wins, sizes add
    assign w_nr  = (w_ret.ra < w_ret.rb) ? w_ret.ra : w_ret.rb;
    assign w_sum = SW'(w_ret.sa + w_ret.sb);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_res_ra   = r_res_ra;
        n_res_rb   = r_res_rb;
        n_res_same = r_res_same;
        n_res_size = r_res_size;
        n_ov       = r_ov;
        n_out_ra   = r_out_ra;
        n_out_rb   = r_out_rb;
        n_out_same = r_out_same;
        n_out_size = r_out_size;
        w_launch   = '0;

        if (o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_launch.vld = 1'b1;
                    w_launch.rel = 1'b0;
                    w_launch.a   = w_wrap[i_in.first_index];
                    // find: look the first element up twice
                    w_launch.b   = (i_in.kind == ufe_pkg::KIND_FIND) ?
                                   w_wrap[i_in.first_index] :
                                   w_wrap[i_in.second_index];
                    n_kind       = i_in.kind;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_ret.vld) begin
                    if (r_kind == ufe_pkg::KIND_UNITE && w_ret.ra != w_ret.rb) begin
                        w_launch.vld = 1'b1;
                        w_launch.rel = 1'b1;
                        w_launch.a   = w_ret.a;
                        w_launch.b   = w_ret.b;
                        w_launch.ra  = w_ret.ra;
                        w_launch.rb  = w_ret.rb;
                        w_launch.nr  = w_nr;
                        w_launch.sa  = w_sum;
                        n_res_ra     = w_nr;
                        n_res_rb     = w_nr;
                        n_res_same   = 1'b1;
                        n_res_size   = w_sum;
                        n_state      = S_REL;
                    end else begin
                        // find, test, unused kind, or unite within one set
                        n_res_ra   = w_ret.ra;
                        n_res_rb   = w_ret.rb;
                        n_res_same = (w_ret.ra == w_ret.rb);
                        n_res_size = w_ret.sa;
                        n_state    = S_DONE;
                    end
                end
            end
            S_REL: begin
                if (w_ret.vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov       = 1'b1;
                    n_out_ra   = r_res_ra;
                    n_out_rb   = r_res_rb;
                    n_out_same = r_res_same;
                    n_out_size = r_res_size;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_res_ra   <= n_res_ra;
        r_res_rb   <= n_res_rb;
        r_res_same <= n_res_same;
        r_res_size <= n_res_size;
        r_out_ra   <= n_out_ra;
        r_out_rb   <= n_out_rb;
        r_out_same <= n_out_same;
        r_out_size <= n_out_size;
    end

    assign o_out.valid       = r_ov;
    assign o_out.root_first  = r_out_ra;
    assign o_out.root_second = r_out_rb;
    assign o_out.same_set    = r_out_same;
    assign o_out.set_size    = r_out_size;

`ifndef SYNTH
    // never more than one token held in the cells
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vlds))
        else $error("more than one token in the cell row");

    // a token only comes back while the controller waits for it
    a_ret_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ret.vld |-> (r_state == S_LOOK || r_state == S_REL))
        else $error("token returned outside a pass");

    // a union result always reports one set
    a_union_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL && w_ret.vld) |=> (r_state == S_DONE && r_res_same))
        else $error("union result not marked as one set");
`endif

endmodule

`default_nettype wire
